/* hdl/assert_macros.svh */
// Assertion helper macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication checked on every rising clock edge outside reset
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/aes_pkg.sv */
// ----------------------------------------------------------------------------
// AES package
// Beat types, request codes, round control, the S-box table with lookups and a GF(2^8) helper.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package aes_pkg;

   typedef enum logic [1:0] {
      REQ_LOAD_KEY = 2'd0,
      REQ_ENCRYPT  = 2'd1,
      REQ_DECRYPT  = 2'd2,
      REQ_NONE     = 2'd3
   } req_kind_type;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [4:0]  key_slot;
      logic [63:0] data_hi;
      logic [63:0] data_lo;
   } req_beat_type;

   typedef struct packed {
      logic [63:0] result_hi;
      logic [63:0] result_lo;
   } rsp_beat_type;

   typedef struct packed {
      logic first;
      logic last;
      logic inverse;
   } round_ctl_type;

   localparam logic [2047:0] SBOX = {
      128'h637c777bf26b6fc53001672bfed7ab76, 128'hca82c97dfa5947f0add4a2af9ca472c0,
      128'hb7fd9326363ff7cc34a5e5f171d83115, 128'h04c723c31896059a071280e2eb27b275,
      128'h09832c1a1b6e5aa0523bd6b329e32f84, 128'h53d100ed20fcb15b6acbbe394a4c58cf,
      128'hd0efaafb434d338545f9027f503c9fa8, 128'h51a3408f929d38f5bcb6da2110fff3d2,
      128'hcd0c13ec5f974417c4a77e3d645d1973, 128'h60814fdc222a908846eeb814de5e0bdb,
      128'he0323a0a4906245cc2d3ac629195e479, 128'he7c8376d8dd54ea96c56f4ea657aae08,
      128'hba78252e1ca6b4c6e8dd741f4bbd8b8a, 128'h703eb5664803f60e613557b986c11d9e,
      128'he1f8981169d98e949b1e87e9ce5528df, 128'h8ca1890dbfe6426841992d0fb054bb16};

   function automatic logic [7:0] sbox_fwd(input logic [7:0] v);
      return SBOX[2047 - 8 * v -: 8];
   endfunction

   function automatic logic [7:0] sbox_inv(input logic [7:0] v);
      logic [7:0] r;
      r = 8'h00;
      for (int i = 0; i < 256; i++) begin
         if (SBOX[2047 - 8 * i -: 8] == v) begin
            r = 8'(i);
         end
      end
      return r;
   endfunction

   function automatic logic [7:0] xt(input logic [7:0] v);
      return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
   endfunction

endpackage

/* hdl/aes_round.sv */
// ----------------------------------------------------------------------------
// AES round unit
// One cipher or inverse cipher round, shared across all rounds of a block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module aes_round (
   input  logic [127:0]          state_in,
   input  logic [127:0]          round_key,
   input  aes_pkg::round_ctl_type ctl,
   output logic [127:0]          state_out
);

   logic [7:0] st  [16];
   logic [7:0] sh  [16];
   logic [7:0] sb  [16];
   logic [7:0] ak  [16];
   logic [7:0] mx  [16];
   logic [7:0] rk  [16];
   logic [7:0] x2  [16];
   logic [7:0] x4  [16];
   logic [7:0] x8  [16];

   always_comb begin
      for (int i = 0; i < 16; i++) begin
         st[i] = state_in[127 - 8 * i -: 8];
         rk[i] = round_key[127 - 8 * i -: 8];
      end
      for (int r = 0; r < 4; r++) begin
         for (int c = 0; c < 4; c++) begin
            if (ctl.inverse) begin
               sh[4 * ((c + r) % 4) + r] = st[4 * c + r];
            end else begin
               sh[4 * c + r] = st[4 * ((c + r) % 4) + r];
            end
         end
      end
      for (int i = 0; i < 16; i++) begin
         sb[i] = ctl.inverse ? aes_pkg::sbox_inv(sh[i]) : aes_pkg::sbox_fwd(sh[i]);
         ak[i] = sb[i] ^ rk[i];
      end
      for (int i = 0; i < 16; i++) begin
         x2[i] = aes_pkg::xt(ctl.inverse ? ak[i] : sb[i]);
         x4[i] = aes_pkg::xt(x2[i]);
         x8[i] = aes_pkg::xt(x4[i]);
      end
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            mx[4 * c + r] = 8'h00;
            for (int j = 0; j < 4; j++) begin
               automatic int k = 4 * c + j;
               automatic int m = (j + 4 - r) % 4;
               if (ctl.inverse) begin
                  unique case (m)
                     0: mx[4 * c + r] ^= x8[k] ^ x4[k] ^ x2[k];
                     1: mx[4 * c + r] ^= x8[k] ^ x2[k] ^ ak[k];
                     2: mx[4 * c + r] ^= x8[k] ^ x4[k] ^ ak[k];
                     default: mx[4 * c + r] ^= x8[k] ^ ak[k];
                  endcase
               end else begin
                  unique case (m)
                     0: mx[4 * c + r] ^= x2[k];
                     1: mx[4 * c + r] ^= x2[k] ^ sb[k];
                     default: mx[4 * c + r] ^= sb[k];
                  endcase
               end
            end
         end
      end
      for (int i = 0; i < 16; i++) begin
         if (ctl.first) begin
            state_out[127 - 8 * i -: 8] = st[i] ^ rk[i];
         end else if (ctl.last || ctl.inverse) begin
            state_out[127 - 8 * i -: 8] = (ctl.last || !ctl.inverse) ? ak[i] : mx[i];
         end else begin
            state_out[127 - 8 * i -: 8] = mx[i] ^ rk[i];
         end
      end
   end

endmodule

/* hdl/aes_block_encrypt_decrypt.sv */
// With nr = round_count clamped to 1..14, a block runs nr + 1 round steps after accept. Each
// step goes through the states KEY0, KEY1 and ROUND: two key store reads, then one pass
// through the shared round unit. A new block is taken only while the sequencer is idle, and
// a held result stalls the next block in its DONE state. Key loads and unused beats are taken
// while idle. Synchronous active-high reset sets round_count to 10 and idles the sequencer;
// key store contents are not reset.
// ----------------------------------------------------------------------------
// AES block engine
// Iterative AES cipher and inverse cipher with a 30 x 64-bit round key store.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module aes_block_encrypt_decrypt #(
   parameter int MAX_ROUNDS = 14
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  aes_pkg::req_beat_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output aes_pkg::rsp_beat_type rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [3:0]            csr_data
);

   localparam int SLOTS  = 2 * (MAX_ROUNDS + 1);
   localparam int SLOT_W = $clog2(SLOTS);

   typedef enum logic [2:0] {
      ST_IDLE, ST_KEY0, ST_KEY1, ST_ROUND, ST_DONE
   } state_type;

   state_type     state_ff;
   logic [3:0]    round_count_ff;
   logic [3:0]    nr_ff;
   logic [3:0]    rnd_ff;
   logic [3:0]    cnt_ff;
   logic          inv_ff;
   logic          first_ff;
   logic [127:0]  blk_ff;
   logic [63:0]   khi_ff;
   logic [63:0]   rd_ff;
   logic [63:0]   mem [SLOTS];
   logic          rsp_valid_ff;
   logic [127:0]  rsp_ff;
   logic [3:0]    nr_in;
   logic [3:0]    rnd_in;
   logic          accept;
   logic [SLOT_W-1:0] rd_addr;
   logic [127:0]  round_out;
   aes_pkg::round_ctl_type ctl;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      if (round_count_ff == 4'd0) begin
         nr_in = 4'd1;
      end else if (round_count_ff > 4'(MAX_ROUNDS)) begin
         nr_in = 4'(MAX_ROUNDS);
      end else begin
         nr_in = round_count_ff;
      end
   end

   // key read address for the round applied in the next step
   always_comb begin
      if (state_ff == ST_IDLE) begin
         rnd_in = (req_data.req_type == aes_pkg::REQ_DECRYPT) ? nr_in : 4'd0;
      end else if (state_ff == ST_ROUND) begin
         rnd_in = inv_ff ? rnd_ff - 4'd1 : rnd_ff + 4'd1;
      end else begin
         rnd_in = rnd_ff;
      end
   end
   assign rd_addr = SLOT_W'({rnd_in, (state_ff == ST_KEY0)});

   assign ctl.first   = first_ff;
   assign ctl.last    = (cnt_ff == nr_ff);
   assign ctl.inverse = inv_ff;

   aes_round u_round (
      .state_in  (blk_ff),
      .round_key ({khi_ff, rd_ff}),
      .ctl       (ctl),
      .state_out (round_out)
   );

   always_ff @(posedge clock) begin
      if (accept && req_data.req_type == aes_pkg::REQ_LOAD_KEY
          && req_data.key_slot < 5'(SLOTS)) begin
         mem[SLOT_W'(req_data.key_slot)] <= req_data.data_hi;
      end
      if (state_ff == ST_IDLE || state_ff == ST_KEY0
          || (state_ff == ST_ROUND && !ctl.last)) begin
         rd_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         round_count_ff <= 4'd10;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            round_count_ff <= csr_data;
         end
         if (state_ff == ST_DONE && (!rsp_valid_ff || !rsp_stall)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (accept && (req_data.req_type == aes_pkg::REQ_ENCRYPT
                              || req_data.req_type == aes_pkg::REQ_DECRYPT)) begin
                  state_ff <= ST_KEY0;
                  blk_ff   <= {req_data.data_hi, req_data.data_lo};
                  inv_ff   <= (req_data.req_type == aes_pkg::REQ_DECRYPT);
                  nr_ff    <= nr_in;
                  rnd_ff   <= rnd_in;
                  cnt_ff   <= 4'd0;
                  first_ff <= 1'b1;
               end
            end
            ST_KEY0: begin
               khi_ff   <= rd_ff;
               state_ff <= ST_KEY1;
            end
            ST_KEY1: begin
               state_ff <= ST_ROUND;
            end
            ST_ROUND: begin
               blk_ff   <= round_out;
               first_ff <= 1'b0;
               cnt_ff   <= cnt_ff + 4'd1;
               rnd_ff   <= rnd_in;
               state_ff <= ST_KEY0;
               if (cnt_ff == nr_ff) begin
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_ff   <= blk_ff;
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   `ASSERT_IMPLY(a_stall_busy, clock, reset, state_ff != ST_IDLE, req_stall, "busy but not stalled")
   `ASSERT_NEXT(a_done_out, clock, reset, state_ff == ST_DONE && !rsp_stall, rsp_valid, "result lost")
   `ASSERT_IMPLY(a_cnt_range, clock, reset, state_ff == ST_ROUND, cnt_ff <= nr_ff, "round overrun")

endmodule

/* dv/tb_aes_block_encrypt_decrypt.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES block engine testbench
// Loads a full round key schedule, then drives directed and random encrypt,
// decrypt, key load and unused beats under several round counts. Results are
// predicted in the bench and checked in order, field by field, while both
// sides idle and stall at random.
// ----------------------------------------------------------------------------

module tb_aes_block_encrypt_decrypt;

   localparam int KEY_HALVES = 30;
   localparam int SETTLE     = 24;
   localparam int CYCLE_CAP  = 1000000;

   localparam logic [2047:0] FWD_SBOX = {
      128'h637c777bf26b6fc53001672bfed7ab76, 128'hca82c97dfa5947f0add4a2af9ca472c0,
      128'hb7fd9326363ff7cc34a5e5f171d83115, 128'h04c723c31896059a071280e2eb27b275,
      128'h09832c1a1b6e5aa0523bd6b329e32f84, 128'h53d100ed20fcb15b6acbbe394a4c58cf,
      128'hd0efaafb434d338545f9027f503c9fa8, 128'h51a3408f929d38f5bcb6da2110fff3d2,
      128'hcd0c13ec5f974417c4a77e3d645d1973, 128'h60814fdc222a908846eeb814de5e0bdb,
      128'he0323a0a4906245cc2d3ac629195e479, 128'he7c8376d8dd54ea96c56f4ea657aae08,
      128'hba78252e1ca6b4c6e8dd741f4bbd8b8a, 128'h703eb5664803f60e613557b986c11d9e,
      128'he1f8981169d98e949b1e87e9ce5528df, 128'h8ca1890dbfe6426841992d0fb054bb16};

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   aes_pkg::req_beat_type req_data;
   logic                  rsp_valid;
   logic                  rsp_stall;
   aes_pkg::rsp_beat_type rsp_data;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [3:0]            csr_data;

   logic [7:0]   fwd_tab [256];
   logic [7:0]   inv_tab [256];
   logic [63:0]  key_halves [KEY_HALVES];
   logic [3:0]   round_setting;
   aes_pkg::rsp_beat_type block_q [$];
   int           mismatches;
   int           blocks_checked;
   int           cycles;
   int           hold_cycles;
   bit           calm;

   aes_block_encrypt_decrypt u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   // ---------------- cipher math ----------------
   function automatic logic [7:0] gf_mul(logic [7:0] a, logic [7:0] b);
      logic [7:0] acc;
      acc = 8'h00;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) acc ^= a;
         a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
      end
      return acc;
   endfunction

   function automatic logic [7:0] st_byte(logic [127:0] s, int i);
      return s[127 - 8 * i -: 8];
   endfunction

   function automatic logic [127:0] subst(logic [127:0] s, bit inv);
      logic [127:0] t;
      for (int i = 0; i < 16; i++) begin
         t[127 - 8 * i -: 8] = inv ? inv_tab[st_byte(s, i)] : fwd_tab[st_byte(s, i)];
      end
      return t;
   endfunction

   function automatic logic [127:0] rotate_rows(logic [127:0] s, bit inv);
      logic [127:0] t;
      for (int r = 0; r < 4; r++) begin
         for (int c = 0; c < 4; c++) begin
            if (inv) t[127 - 8 * (4 * ((c + r) % 4) + r) -: 8] = st_byte(s, 4 * c + r);
            else     t[127 - 8 * (4 * c + r) -: 8] = st_byte(s, 4 * ((c + r) % 4) + r);
         end
      end
      return t;
   endfunction

   function automatic logic [127:0] mix_cols(logic [127:0] s, bit inv);
      logic [7:0]   m [4];
      logic [7:0]   acc;
      logic [127:0] t;
      if (inv) m = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
      else     m = '{8'h02, 8'h03, 8'h01, 8'h01};
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            acc = 8'h00;
            for (int j = 0; j < 4; j++) acc ^= gf_mul(st_byte(s, 4 * c + j), m[(j + 4 - r) % 4]);
            t[127 - 8 * (4 * c + r) -: 8] = acc;
         end
      end
      return t;
   endfunction

   function automatic logic [127:0] rkey(int rnd);
      return {key_halves[2 * rnd], key_halves[2 * rnd + 1]};
   endfunction

   function automatic logic [127:0] aes_block(logic [127:0] blk, bit inv);
      int nr;
      logic [127:0] s;
      nr = (round_setting == 0) ? 1 : (round_setting > 14) ? 14 : round_setting;
      if (!inv) begin
         s = blk ^ rkey(0);
         for (int rnd = 1; rnd < nr; rnd++) begin
            s = mix_cols(rotate_rows(subst(s, 0), 0), 0) ^ rkey(rnd);
         end
         s = rotate_rows(subst(s, 0), 0) ^ rkey(nr);
      end else begin
         s = blk ^ rkey(nr);
         for (int rnd = nr - 1; rnd > 0; rnd--) begin
            s = mix_cols(subst(rotate_rows(s, 1), 1) ^ rkey(rnd), 1);
         end
         s = subst(rotate_rows(s, 1), 1) ^ rkey(0);
      end
      return s;
   endfunction

   function automatic void track_beat(aes_pkg::req_beat_type b);
      aes_pkg::rsp_beat_type e;
      case (b.req_type)
         aes_pkg::REQ_LOAD_KEY: begin
            if (b.key_slot < KEY_HALVES) key_halves[b.key_slot] = b.data_hi;
         end
         aes_pkg::REQ_ENCRYPT, aes_pkg::REQ_DECRYPT: begin
            {e.result_hi, e.result_lo} =
               aes_block({b.data_hi, b.data_lo}, b.req_type == aes_pkg::REQ_DECRYPT);
            block_q.push_back(e);
         end
         default: ;
      endcase
   endfunction

   // ---------------- receiver and checker ----------------
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_cycles > 0) begin
         rsp_stall <= 1'b1;
         hold_cycles = hold_cycles - 1;
      end else begin
         rsp_stall <= !calm && ($urandom_range(99) < 22);
      end
   end

   always @(posedge clock) begin
      aes_pkg::rsp_beat_type e;
      cycles <= cycles + 1;
      if (cycles > CYCLE_CAP) begin
         $display("Timeout after %0d cycles", cycles);
         $display("Mismatches found");
         $finish;
      end else if (!reset && rsp_valid && !rsp_stall) begin
         if (block_q.size() == 0) begin
            $error("unexpected result beat %h", rsp_data);
            mismatches++;
         end else begin
            e = block_q.pop_front();
            blocks_checked++;
            if (rsp_data.result_hi !== e.result_hi) begin
               $error("result_hi expected %h actual %h", e.result_hi, rsp_data.result_hi);
               mismatches++;
            end
            if (rsp_data.result_lo !== e.result_lo) begin
               $error("result_lo expected %h actual %h", e.result_lo, rsp_data.result_lo);
               mismatches++;
            end
         end
      end
   end

   // ---------------- sender side ----------------
   task automatic send_beat(aes_pkg::req_beat_type b);
      int gap;
      gap = (calm || $urandom_range(99) >= 22) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= b;
      do @(posedge clock); while (req_stall);
      track_beat(b);
   endtask

   task automatic send_op(aes_pkg::req_kind_type k, logic [4:0] slot, logic [63:0] hi,
                          logic [63:0] lo);
      aes_pkg::req_beat_type b;
      b.req_type = k;
      b.key_slot = slot;
      b.data_hi  = hi;
      b.data_lo  = lo;
      send_beat(b);
   endtask

   task automatic drain;
      @(negedge clock);
      req_valid <= 1'b0;
      while (block_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic set_rounds(logic [3:0] v);
      drain();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= v;
      do @(posedge clock); while (!csr_ready);
      round_setting = v;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   task automatic random_beat();
      int pick;
      pick = $urandom_range(99);
      if (pick < 10)
         send_op(aes_pkg::REQ_LOAD_KEY, 5'($urandom_range(31)), rand64(), rand64());
      else if (pick < 14)
         send_op(aes_pkg::REQ_NONE, 5'($urandom_range(31)), rand64(), rand64());
      else
         send_op(pick < 57 ? aes_pkg::REQ_ENCRYPT : aes_pkg::REQ_DECRYPT,
                 5'($urandom_range(31)), rand64(), rand64());
   endtask

   // ---------------- tests ----------------
   task automatic test_key_load;
      for (int i = 0; i < KEY_HALVES; i++)
         send_op(aes_pkg::REQ_LOAD_KEY, 5'(i), rand64(), rand64());
   endtask

   task automatic test_directed;
      send_op(aes_pkg::REQ_ENCRYPT, '0, '0, '0);
      send_op(aes_pkg::REQ_ENCRYPT, '1, '1, '1);
      send_op(aes_pkg::REQ_DECRYPT, '0, '0, '0);
      send_op(aes_pkg::REQ_DECRYPT, '1, '1, '1);
      send_op(aes_pkg::REQ_LOAD_KEY, 5'd30, rand64(), rand64());
      send_op(aes_pkg::REQ_LOAD_KEY, 5'd31, rand64(), rand64());
      send_op(aes_pkg::REQ_NONE, 5'd7, rand64(), rand64());
      send_op(aes_pkg::REQ_LOAD_KEY, 5'd0, '1, '0);
      send_op(aes_pkg::REQ_LOAD_KEY, 5'd29, '0, '1);
      send_op(aes_pkg::REQ_ENCRYPT, 5'd0, 64'h0123456789abcdef, 64'hfedcba9876543210);
      send_op(aes_pkg::REQ_DECRYPT, 5'd0, 64'h0123456789abcdef, 64'hfedcba9876543210);
   endtask

   task automatic test_round_extremes;
      logic [3:0] vals [9] = '{4'd12, 4'd14, 4'd0, 4'd1, 4'd15, 4'd9, 4'd11, 4'd13, 4'd10};
      foreach (vals[i]) begin
         set_rounds(vals[i]);
         send_op(aes_pkg::REQ_ENCRYPT, '0, rand64(), rand64());
         send_op(aes_pkg::REQ_DECRYPT, '0, rand64(), rand64());
      end
   endtask

   task automatic test_backpressure;
      drain();
      calm = 1'b1;
      @(negedge clock);
      hold_cycles = 400;
      for (int i = 0; i < 30; i++) send_op(aes_pkg::REQ_ENCRYPT, '0, rand64(), rand64());
      calm = 1'b0;
      drain();
   endtask

   task automatic test_random;
      for (int phase = 0; phase < 12; phase++) begin
         set_rounds(phase == 0 ? 4'd10 : 4'($urandom_range(15)));
         calm = (phase == 3);
         for (int i = 0; i < 120; i++) random_beat();
         calm = 1'b0;
      end
   endtask

   initial begin
      for (int i = 0; i < 256; i++) begin
         fwd_tab[i] = FWD_SBOX[2047 - 8 * i -: 8];
         inv_tab[fwd_tab[i]] = 8'(i);
      end
      round_setting  = 4'd10;
      mismatches     = 0;
      blocks_checked = 0;
      cycles         = 0;
      hold_cycles    = 0;
      calm           = 1'b0;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_data       = '0;
      csr_valid      = 1'b0;
      csr_data       = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_key_load();
      test_directed();
      test_round_extremes();
      test_backpressure();
      test_random();
      drain();

      $display("Covered key loads, unused beats and %0d checked blocks", blocks_checked);
      $display("across round counts 0 to 15 with random stalls and a long output hold.");
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
